// ===== hw/rtl/ehcd_pkg.sv =====
// ----------------------------------------------------------------------------
// ehcd_pkg
// Shared types and constants of the elevator hall-call dispatch core.
// ----------------------------------------------------------------------------
`default_nettype none

package ehcd_pkg;

    localparam int CFG_BITS  = 4;
    localparam int CAR_BITS  = 3;
    localparam int TIER_BITS = 2;

    localparam logic [CFG_BITS-1:0] CARS_IN_USE_RST = 4'd8;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CALL   = 1'b1;

    localparam logic [TIER_BITS-1:0] TIER_SAME = 2'd0;
    localparam logic [TIER_BITS-1:0] TIER_IDLE = 2'd1;
    localparam logic [TIER_BITS-1:0] TIER_OPP  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic eval;
    } score_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ehcd_score.sv =====
// ----------------------------------------------------------------------------
// ehcd_score
// Per-tier best-car tracker: takes one table entry per cycle while eval is set and keeps the
// nearest candidate of each tier; the result is the first tier with a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module ehcd_score #(
    parameter int FLOOR_BITS = 6,
    parameter int AW         = 3
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ehcd_pkg::score_ctl_t               ctl,
    input  wire logic [AW-1:0]                      e_index,
    input  wire logic                               e_idle,
    input  wire logic                               e_up,
    input  wire logic [FLOOR_BITS-1:0]              e_floor,
    input  wire logic                               e_up_valid,
    input  wire logic [FLOOR_BITS-1:0]              e_up_floor,
    input  wire logic                               e_down_valid,
    input  wire logic [FLOOR_BITS-1:0]              e_down_floor,
    input  wire logic [FLOOR_BITS-1:0]              call_floor,
    input  wire logic                               call_up,
    output logic                                    assigned,
    output logic [ehcd_pkg::CAR_BITS-1:0]           chosen_car,
    output logic [ehcd_pkg::TIER_BITS-1:0]          tier
);

    logic                  vld_reg  [3];
    logic                  vld_next [3];
    logic [FLOOR_BITS-1:0] gap_reg  [3];
    logic [FLOOR_BITS-1:0] gap_next [3];
    logic [AW-1:0]         idx_reg  [3];
    logic [AW-1:0]         idx_next [3];

    logic                  cand [3];
    logic [FLOOR_BITS-1:0] gap  [3];
    logic                  ahead;
    logic [FLOOR_BITS-1:0] task_floor;
    logic                  task_ok;
    logic [FLOOR_BITS-1:0] car_gap;

    always_comb
    begin
        ahead      = (e_up == call_up) &&
                     (call_up ? (call_floor > e_floor) : (e_floor > call_floor));
        task_floor = e_up ? e_up_floor : e_down_floor;
        task_ok    = e_up ? e_up_valid : e_down_valid;
        car_gap    = (e_floor > call_floor) ? (e_floor - call_floor)
                                            : (call_floor - e_floor);

        cand[0] = !e_idle && ahead;
        gap[0]  = car_gap;
        cand[1] = e_idle;
        gap[1]  = car_gap;
        cand[2] = !e_idle && !ahead && task_ok;
        gap[2]  = (task_floor > call_floor) ? (task_floor - call_floor)
                                            : (call_floor - task_floor);
    end

    // ascending scan with strict compare: ties keep the lower index
    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            vld_next[t] = vld_reg[t];
            gap_next[t] = gap_reg[t];
            idx_next[t] = idx_reg[t];
            if (ctl.clear)
            begin
                vld_next[t] = 1'b0;
            end
            else if (ctl.eval && cand[t] && (!vld_reg[t] || gap[t] < gap_reg[t]))
            begin
                vld_next[t] = 1'b1;
                gap_next[t] = gap[t];
                idx_next[t] = e_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 3; t++)
            begin
                vld_reg[t] <= 1'b0;
            end
        end
        else
        begin
            for (int t = 0; t < 3; t++)
            begin
                vld_reg[t] <= vld_next[t];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int t = 0; t < 3; t++)
        begin
            gap_reg[t] <= gap_next[t];
            idx_reg[t] <= idx_next[t];
        end
    end

    always_comb
    begin
        assigned   = vld_reg[0] || vld_reg[1] || vld_reg[2];
        chosen_car = '0;
        tier       = ehcd_pkg::TIER_SAME;
        if (vld_reg[0])
        begin
            chosen_car = ehcd_pkg::CAR_BITS'(idx_reg[0]);
        end
        else if (vld_reg[1])
        begin
            chosen_car = ehcd_pkg::CAR_BITS'(idx_reg[1]);
            tier       = ehcd_pkg::TIER_IDLE;
        end
        else if (vld_reg[2])
        begin
            chosen_car = ehcd_pkg::CAR_BITS'(idx_reg[2]);
            tier       = ehcd_pkg::TIER_OPP;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/elevator_hall_call_dispatch_core.sv =====
// ----------------------------------------------------------------------------
// elevator_hall_call_dispatch_core
// Car status table in a synchronous memory and a hall-call dispatcher that
// scans it one entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//  Command channel: an item is taken when start is high and busy is low.
//  cmd = update writes one status entry at that edge; no result, busy stays
//  low, so another item may follow in the next cycle.
//  cmd = call starts a scan over min(cars_in_use, NUM_CARS) entries, one
//  memory read per cycle, each read's data registered before it is scored.
//  busy stays high through the scan; the result shows in the last cycle of
//  busy with done high for exactly one cycle. It cannot be held off.
//  Config: cfg_we writes cars_in_use from cfg_wdata; write only while idle.
//  Reset: cars_in_use returns to 8; per-entry valid bits clear at once, so
//  every entry reads as idle at floor zero with no tasks. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module elevator_hall_call_dispatch_core #(
    parameter int NUM_CARS   = 8,
    parameter int FLOOR_BITS = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ehcd_pkg::CFG_BITS-1:0]      cfg_wdata,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               cmd,
    input  wire logic [ehcd_pkg::CAR_BITS-1:0]      car_index,
    input  wire logic                               car_idle,
    input  wire logic                               car_going_up,
    input  wire logic [FLOOR_BITS-1:0]              car_floor,
    input  wire logic                               top_up_valid,
    input  wire logic [FLOOR_BITS-1:0]              top_up_floor,
    input  wire logic                               low_down_valid,
    input  wire logic [FLOOR_BITS-1:0]              low_down_floor,
    input  wire logic [FLOOR_BITS-1:0]              call_floor,
    input  wire logic                               call_up,
    output logic                                    done,
    output logic                                    assigned,
    output logic [ehcd_pkg::CAR_BITS-1:0]           chosen_car,
    output logic [ehcd_pkg::TIER_BITS-1:0]          tier
);

    localparam int AW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int CW = $clog2(NUM_CARS + 1);
    localparam int EW = 4 + 3 * FLOOR_BITS;

    ehcd_pkg::state_t               state_reg, state_next;
    logic [ehcd_pkg::CFG_BITS-1:0]  cars_in_use_reg;
    logic [CW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic                           ev_vld_reg;
    logic [AW-1:0]                  ev_idx_reg;
    logic [FLOOR_BITS-1:0]          call_floor_reg;
    logic                           call_up_reg;

    logic [EW-1:0]                  mem [NUM_CARS];
    logic [NUM_CARS-1:0]            entry_ok_reg;
    logic [EW-1:0]                  rd_data_reg;
    logic                           rd_ok_reg;
    logic [EW-1:0]                  entry;

    logic                           accept;
    logic                           accept_call;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    ehcd_pkg::score_ctl_t           score_ctl;

    assign accept      = start && !busy;
    assign accept_call = accept && (cmd == ehcd_pkg::CMD_CALL);
    assign wr_en       = accept && (cmd == ehcd_pkg::CMD_UPDATE) &&
                         (int'(car_index) < NUM_CARS);
    assign wr_addr     = AW'(car_index);
    assign rd_addr     = rd_idx_reg[AW-1:0];

    // state table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {car_idle, car_going_up, car_floor, top_up_valid,
                             top_up_floor, low_down_valid, low_down_floor};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_ok_reg <= '0;
            rd_ok_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_ok_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= entry_ok_reg[rd_addr];
            end
        end
    end

    // unwritten entry: idle, down, floor zero, no tasks
    assign entry = rd_ok_reg ? rd_data_reg : {1'b1, {(EW-1){1'b0}}};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ehcd_pkg::ST_IDLE:
            begin
                if (accept_call)
                begin
                    state_next = ehcd_pkg::ST_SCAN;
                end
            end
            ehcd_pkg::ST_SCAN:
            begin
                if (rd_idx_reg >= n_reg)
                begin
                    state_next = ehcd_pkg::ST_DONE;
                end
            end
            ehcd_pkg::ST_DONE:
            begin
                state_next = ehcd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ehcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy            = 1'b1;
        done            = 1'b0;
        rd_en           = 1'b0;
        score_ctl.clear = 1'b0;
        score_ctl.eval  = ev_vld_reg;
        case (state_reg)
            ehcd_pkg::ST_IDLE:
            begin
                busy            = 1'b0;
                score_ctl.clear = start && (cmd == ehcd_pkg::CMD_CALL);
            end
            ehcd_pkg::ST_SCAN:
            begin
                rd_en = rd_idx_reg < n_reg;
            end
            ehcd_pkg::ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        n_next      = n_reg;
        if (accept_call)
        begin
            rd_idx_next = '0;
            if (int'(cars_in_use_reg) > NUM_CARS)
            begin
                n_next = CW'(NUM_CARS);
            end
            else
            begin
                n_next = CW'(cars_in_use_reg);
            end
        end
        else if (rd_en)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ehcd_pkg::ST_IDLE;
            cars_in_use_reg <= ehcd_pkg::CARS_IN_USE_RST;
            rd_idx_reg      <= '0;
            n_reg           <= '0;
            ev_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            n_reg      <= n_next;
            ev_vld_reg <= rd_en;
            if (cfg_we)
            begin
                cars_in_use_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            ev_idx_reg <= rd_addr;
        end
        if (accept_call)
        begin
            call_floor_reg <= call_floor;
            call_up_reg    <= call_up;
        end
    end

    ehcd_score #(
        .FLOOR_BITS (FLOOR_BITS),
        .AW         (AW)
    ) u_score (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (score_ctl),
        .e_index      (ev_idx_reg),
        .e_idle       (entry[EW-1]),
        .e_up         (entry[EW-2]),
        .e_floor      (entry[EW-3 -: FLOOR_BITS]),
        .e_up_valid   (entry[2*FLOOR_BITS+1]),
        .e_up_floor   (entry[2*FLOOR_BITS -: FLOOR_BITS]),
        .e_down_valid (entry[FLOOR_BITS]),
        .e_down_floor (entry[FLOOR_BITS-1:0]),
        .call_floor   (call_floor_reg),
        .call_up      (call_up_reg),
        .assigned     (assigned),
        .chosen_car   (chosen_car),
        .tier         (tier)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ehcd_checker.sv =====
// ----------------------------------------------------------------------------
// ehcd_checker
// Port-level checks of the dispatch core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ehcd_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               busy,
    input  wire logic                               cmd,
    input  wire logic                               done,
    input  wire logic                               assigned,
    input  wire logic [ehcd_pkg::CAR_BITS-1:0]      chosen_car,
    input  wire logic [ehcd_pkg::TIER_BITS-1:0]     tier
);

    a_call_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == ehcd_pkg::CMD_CALL) |=> busy)
        else $error("call item did not raise busy");

    a_update_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == ehcd_pkg::CMD_UPDATE) |=> !busy && !done)
        else $error("status update stalled the channel");

    a_done_then_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 (!busy && !done))
        else $error("result not at the end of a busy period");

    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !assigned |-> (chosen_car == '0) && (tier == ehcd_pkg::TIER_SAME))
        else $error("unassigned result carries a car or tier");

    a_tier_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tier == ehcd_pkg::TIER_SAME) || (tier == ehcd_pkg::TIER_IDLE) ||
                 (tier == ehcd_pkg::TIER_OPP))
        else $error("illegal tier code");

endmodule

bind elevator_hall_call_dispatch_core ehcd_checker u_ehcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .assigned   (assigned),
    .chosen_car (chosen_car),
    .tier       (tier)
);

`default_nettype wire
